// ===== rtl/tfsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfsm_pkg
// Shared types, command codes and frame constants of the serial frame master.
// ----------------------------------------------------------------------------
`default_nettype none

package tfsm_pkg;

  // Frame layout and counter widths
  localparam int unsigned FRAME_BITS = 12;
  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned SKIP_BITS  = 3;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned HUNT_W     = 9;
  localparam int unsigned IDLE_W     = 7;

  localparam logic [FRAME_BITS-1:0] STOP_BITS_MASK = 12'hC00;

  // Limits and reset values of the configuration registers
  localparam logic [HUNT_W-1:0] HUNT_MAX   = 9'd256;
  localparam logic [HUNT_W-1:0] HUNT_RESET = 9'd256;
  localparam logic [IDLE_W-1:0] IDLE_MAX   = 7'd64;
  localparam logic [IDLE_W-1:0] IDLE_RESET = 7'd16;

  // Register word index on the configuration port
  localparam logic REG_HUNT = 1'b0;
  localparam logic REG_IDLE = 1'b1;

  // Request command codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SEND = 2'd1;
  localparam logic [1:0] FUNC_RECV = 2'd2;
  localparam logic [1:0] FUNC_ONES = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_SEND = 4'b0010,
    MODE_RECV = 4'b0100,
    MODE_ONES = 4'b1000
  } mode_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_DATA = 3'b010,
    PH_SKIP = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       line_sample;
  } item_t;

  typedef struct packed {
    logic       data_level;
    logic       data_drive;
    logic [7:0] rx_byte;
    logic       start_timeout;
    logic       op_done;
  } res_t;

  // Map a start command to its operating mode
  function automatic mode_t func_to_mode(input logic [1:0] func);
    mode_t m;
    case (func)
      FUNC_SEND: m = MODE_SEND;
      FUNC_RECV: m = MODE_RECV;
      FUNC_ONES: m = MODE_ONES;
      default:   m = MODE_IDLE;
    endcase
    return m;
  endfunction

  // Start bit, data LSB first, even parity, two stop bits
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [7:0] b);
    return {2'b00, ^b, b, 1'b0} | STOP_BITS_MASK;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tfsm_core.sv =====
// ----------------------------------------------------------------------------
// tfsm_core
// Operation state of the frame master and the per-slot step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsm_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          step_en,
  input  tfsm_pkg::item_t              item,
  input  wire [tfsm_pkg::HUNT_W-1:0]   hunt_limit,
  input  wire [tfsm_pkg::IDLE_W-1:0]   idle_ones,
  output logic                         res_valid,
  output tfsm_pkg::res_t               res
);
  import tfsm_pkg::*;

  mode_t                 mode_r,  mode_e,  mode_nxt;
  phase_t                phase_r, phase_e, phase_nxt;
  logic [CNT_W-1:0]      cnt_r,   cnt_e,   cnt_nxt, cnt_inc;
  logic [FRAME_BITS-1:0] tx_r,    tx_e,    tx_nxt;
  logic [7:0]            rx_r,    rx_e,    rx_nxt;
  logic                  tmo_r,   tmo_e,   tmo_nxt;
  logic                  done;
  logic [HUNT_W-1:0]     hunt_eff;
  logic [IDLE_W-1:0]     idle_eff;

  // Clamp the limits into their legal range
  always_comb begin
    if (hunt_limit == '0) begin
      hunt_eff = HUNT_W'(1);
    end else if (hunt_limit > HUNT_MAX) begin
      hunt_eff = HUNT_MAX;
    end else begin
      hunt_eff = hunt_limit;
    end
    if (idle_ones == '0) begin
      idle_eff = IDLE_W'(1);
    end else if (idle_ones > IDLE_MAX) begin
      idle_eff = IDLE_MAX;
    end else begin
      idle_eff = idle_ones;
    end
  end

  // A command restarts the operation in this same slot
  always_comb begin
    mode_e  = mode_r;
    phase_e = phase_r;
    cnt_e   = cnt_r;
    tx_e    = tx_r;
    rx_e    = rx_r;
    tmo_e   = tmo_r;
    if (item.func != FUNC_TICK) begin
      mode_e  = func_to_mode(item.func);
      phase_e = PH_HUNT;
      cnt_e   = '0;
      rx_e    = '0;
      tmo_e   = 1'b0;
      tx_e    = (item.func == FUNC_SEND) ? build_frame(item.tx_byte) : '0;
    end
  end

  // One bit slot of the active operation
  always_comb begin
    cnt_inc   = cnt_e + CNT_W'(1);
    mode_nxt  = mode_e;
    phase_nxt = phase_e;
    cnt_nxt   = cnt_e;
    tx_nxt    = tx_e;
    rx_nxt    = rx_e;
    tmo_nxt   = tmo_e;
    done      = 1'b0;
    res       = '0;
    res_valid = (mode_e != MODE_IDLE);
    case (mode_e)
      MODE_SEND: begin
        res.data_drive = 1'b1;
        res.data_level = tx_e[0];
        tx_nxt         = tx_e >> 1;
        cnt_nxt        = cnt_inc;
        done           = (cnt_inc >= CNT_W'(FRAME_BITS));
      end
      MODE_ONES: begin
        res.data_drive = 1'b1;
        res.data_level = 1'b1;
        cnt_nxt        = cnt_inc;
        done           = (cnt_inc >= CNT_W'(idle_eff));
      end
      MODE_RECV: begin
        case (phase_e)
          PH_HUNT: begin
            cnt_nxt = cnt_inc;
            if (!item.line_sample) begin
              phase_nxt = PH_DATA;
              cnt_nxt   = '0;
            end else if (cnt_inc >= hunt_eff) begin
              tmo_nxt   = 1'b1;
              phase_nxt = PH_DATA;
              cnt_nxt   = '0;
            end
          end
          PH_DATA: begin
            rx_nxt  = rx_e | (8'(item.line_sample) << cnt_e[2:0]);
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CNT_W'(DATA_BITS)) begin
              phase_nxt = PH_SKIP;
              cnt_nxt   = '0;
            end
          end
          default: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CNT_W'(SKIP_BITS)) begin
              done              = 1'b1;
              res.rx_byte       = rx_e;
              res.start_timeout = tmo_e;
            end
          end
        endcase
      end
      default: ;
    endcase
    res.op_done = done;
    // Drop back to idle after the last slot
    if (done) begin
      mode_nxt  = MODE_IDLE;
      phase_nxt = PH_HUNT;
      cnt_nxt   = '0;
    end
  end

  // Advance the operation state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      tmo_r   <= 1'b0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      tmo_r   <= tmo_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpi_frame_serial_master_top.sv =====
// A request passes through the input register, then the result register.
// Throughput: one request per cycle; the result register is the only limit,
// and a stalled result holds the input side for as long as it waits.
// Reset (rst_n low, synchronous): no operation active, hunt_limit 256,
// idle_ones 16, both channels empty.
// ----------------------------------------------------------------------------
// tpi_frame_serial_master_top
// Serial frame master for a two-wire programming link, one bit slot per
// request, with an APB register port for the hunt and idle limits.
// ----------------------------------------------------------------------------
`default_nettype none

module tpi_frame_serial_master_top (
  input  wire         clk,
  input  wire         rst_n,
  // request channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_func,
  input  wire  [7:0]  in_tx_byte,
  input  wire         in_line_sample,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_data_level,
  output logic        out_data_drive,
  output logic [7:0]  out_rx_byte,
  output logic        out_start_timeout,
  output logic        out_op_done,
  // register port
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tfsm_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;
  logic              out_blocked, advance, in_accept;
  logic              core_valid;
  res_t              core_res;
  logic [HUNT_W-1:0] hunt_r;
  logic [IDLE_W-1:0] idle_r;
  logic              cfg_wr;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunt_r <= HUNT_RESET;
      idle_r <= IDLE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_HUNT: hunt_r <= cfg_pwdata[HUNT_W-1:0];
        REG_IDLE: idle_r <= cfg_pwdata[IDLE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_HUNT: cfg_prdata = 32'(hunt_r);
      REG_IDLE: cfg_prdata = 32'(idle_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // Handshake: stage moves on unless a held result blocks it
  assign out_blocked = out_valid_r & out_stall;
  assign advance     = s1_valid_r & ~out_blocked;
  assign in_stall    = s1_valid_r & out_blocked;
  assign in_accept   = in_valid & ~in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = core_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{func: in_func, tx_byte: in_tx_byte, line_sample: in_line_sample};
    end
  end

  tfsm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .item       (s1_item_r),
    .hunt_limit (hunt_r),
    .idle_ones  (idle_r),
    .res_valid  (core_valid),
    .res        (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_level    = out_res_r.data_level;
  assign out_data_drive    = out_res_r.data_drive;
  assign out_rx_byte       = out_res_r.rx_byte;
  assign out_start_timeout = out_res_r.start_timeout;
  assign out_op_done       = out_res_r.op_done;

endmodule

`default_nettype wire

// ===== rtl/tfsm_checker.sv =====
// ----------------------------------------------------------------------------
// tfsm_checker
// Port-level checks of the serial frame master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tfsm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire        out_data_level,
  input wire        out_data_drive,
  input wire [7:0]  out_rx_byte,
  input wire        out_start_timeout,
  input wire        out_op_done
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rx_byte)
      && $stable(out_op_done) && $stable(out_data_level)
      && $stable(out_data_drive) && $stable(out_start_timeout))
    else $error("result changed while stalled");

  // Input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a held result");

  // Released line reads low on the driven level
  a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_drive |-> !out_data_level)
    else $error("level set while line released");

  // Received byte and timeout appear only on a last receive slot
  a_rx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_op_done || out_data_drive)
      |-> out_rx_byte == 8'h00 && !out_start_timeout)
    else $error("receive fields set outside a finished receive");

endmodule

bind tpi_frame_serial_master_top tfsm_checker u_tfsm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_data_level    (out_data_level),
  .out_data_drive    (out_data_drive),
  .out_rx_byte       (out_rx_byte),
  .out_start_timeout (out_start_timeout),
  .out_op_done       (out_op_done)
);

`default_nettype wire
